// File: rtl/core/biqd_pkg.sv
// Shared types and constants for the band-pass biquad filter.
`timescale 1ns / 1ps

package biqd_pkg;

  localparam int COEF_W     = 8;   // width of every configuration register
  localparam int CFG_IDX_W  = 4;   // register index width on the config port
  localparam int Y_W        = 16;  // stored output history width
  localparam int OUT_W      = 16;  // result width
  localparam int FRAC_SHIFT = 8;   // coefficients are in units of 1/256
  localparam int OUT_SHIFT  = 2;   // output scale: y times four

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_ONE_FRAC   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_TWO        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_OFFSET = 4'd3;

  // Reset values
  localparam logic [COEF_W-1:0] INPUT_GAIN_RST    = 8'd40;
  localparam logic [COEF_W-1:0] FB_ONE_FRAC_RST   = 8'd9;
  localparam logic [COEF_W-1:0] FB_TWO_RST        = 8'd176;
  localparam logic [COEF_W-1:0] OUTPUT_OFFSET_RST = 8'd127;

  typedef struct packed {
    logic [COEF_W-1:0] input_gain;
    logic [COEF_W-1:0] feedback_one_fraction;
    logic [COEF_W-1:0] feedback_two;
    logic [COEF_W-1:0] output_offset;
  } cfg_t;

endpackage

// File: rtl/core/biqd_if.sv
// Valid/ready request channels for input samples and filtered samples.
`timescale 1ns / 1ps

interface biqd_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biqd_out_if;
  logic                          valid;
  logic                          ready;
  logic [biqd_pkg::OUT_W-1:0]    sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: rtl/core/biqd_cfg_regs.sv
// Configuration register bank for the biquad filter.
`timescale 1ns / 1ps

module biqd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [biqd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [biqd_pkg::COEF_W-1:0]    cfg_data,
  output biqd_pkg::cfg_t                 cfg
);

  biqd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.input_gain            <= biqd_pkg::INPUT_GAIN_RST;
      cfg_q.feedback_one_fraction <= biqd_pkg::FB_ONE_FRAC_RST;
      cfg_q.feedback_two          <= biqd_pkg::FB_TWO_RST;
      cfg_q.output_offset         <= biqd_pkg::OUTPUT_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        biqd_pkg::REG_INPUT_GAIN:    cfg_q.input_gain            <= cfg_data;
        biqd_pkg::REG_FB_ONE_FRAC:   cfg_q.feedback_one_fraction <= cfg_data;
        biqd_pkg::REG_FB_TWO:        cfg_q.feedback_two          <= cfg_data;
        biqd_pkg::REG_OUTPUT_OFFSET: cfg_q.output_offset         <= cfg_data;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

// File: rtl/core/biqd_datapath.sv
// Combinational biquad arithmetic: new y and the scaled output.
`timescale 1ns / 1ps

module biqd_datapath #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic [SAMPLE_BITS-1:0]     x,
  input  logic [SAMPLE_BITS-1:0]     x2,
  input  logic [biqd_pkg::Y_W-1:0]   y1,
  input  logic [biqd_pkg::Y_W-1:0]   y2,
  input  biqd_pkg::cfg_t             cfg,
  output logic [biqd_pkg::Y_W-1:0]   y_new,
  output logic [biqd_pkg::OUT_W-1:0] result
);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int FF_W   = DIFF_W + biqd_pkg::COEF_W + 1;
  localparam int FB_W   = biqd_pkg::Y_W + biqd_pkg::COEF_W + 1;

  logic signed [DIFF_W-1:0]        diff;
  logic signed [FF_W-1:0]          ff_prod;
  logic signed [FB_W-1:0]          fb1_prod;
  logic signed [FB_W-1:0]          fb2_prod;
  logic signed [FF_W-1:0]          ff_fl;
  logic signed [FB_W-1:0]          fb1_fl;
  logic signed [FB_W-1:0]          fb2_fl;

  assign diff = $signed({1'b0, x}) - $signed({1'b0, x2});

  // Coefficients are unsigned: zero-extend to keep the products signed.
  assign ff_prod  = $signed({1'b0, cfg.input_gain}) * diff;
  assign fb1_prod = $signed({1'b0, cfg.feedback_one_fraction}) * $signed(y1);
  assign fb2_prod = $signed({1'b0, cfg.feedback_two}) * $signed(y2);

  // Arithmetic shift gives floor toward minus infinity.
  assign ff_fl  = ff_prod  >>> biqd_pkg::FRAC_SHIFT;
  assign fb1_fl = fb1_prod >>> biqd_pkg::FRAC_SHIFT;
  assign fb2_fl = fb2_prod >>> biqd_pkg::FRAC_SHIFT;

  // Only the low 16 bits survive the store, so the sum runs mod 2^16.
  assign y_new = ff_fl[biqd_pkg::Y_W-1:0] + y1 + fb1_fl[biqd_pkg::Y_W-1:0]
               - fb2_fl[biqd_pkg::Y_W-1:0];

  assign result = {y_new[biqd_pkg::OUT_W-biqd_pkg::OUT_SHIFT-1:0],
                   {biqd_pkg::OUT_SHIFT{1'b0}}}
                + {{(biqd_pkg::OUT_W-biqd_pkg::COEF_W){1'b0}}, cfg.output_offset};

endmodule

// File: rtl/core/iir_biquad_bandpass_unit.sv
// Top level of the second-order band-pass IIR filter.
`timescale 1ns / 1ps

// Channel  Dir  Payload                    Handshake
// din      in   sample_in [SAMPLE_BITS]    valid/ready, one sample per request
// dout     out  sample_out [16]            valid/ready, one result per request
// cfg      in   cfg_index [4], cfg_data[8] cfg_we, write-only, no stall
//
// Two register stages: an input register, then the filter arithmetic into the
// result register. An accepted sample passes through the input register before
// its result loads the result register and raises dout.valid.
// One sample per cycle sustained while dout does not stall; the y1/y2 feedback
// closes through the history registers updated as the result register loads.
// A stall on dout backs up through both stages; the input register keeps
// its sample and history only moves when a result is loaded.
// Synchronous active-high reset clears the valids and history and loads the config reset values.

module iir_biquad_bandpass_unit #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [biqd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [biqd_pkg::COEF_W-1:0]    cfg_data,
  biqd_in_if.sink                        din,
  biqd_out_if.source                     dout
);

  biqd_pkg::cfg_t cfg;

  // input register stage
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_x;
  logic                   s1_fire;   // s1 moves into the result register
  logic                   in_fire;

  // filter history
  logic [SAMPLE_BITS-1:0]   in_hist0;
  logic [SAMPLE_BITS-1:0]   in_hist1;
  logic [biqd_pkg::Y_W-1:0] out_hist0;
  logic [biqd_pkg::Y_W-1:0] out_hist1;

  // result register
  logic                     out_valid;
  logic [biqd_pkg::OUT_W-1:0] out_data;

  logic [biqd_pkg::Y_W-1:0]   y_new;
  logic [biqd_pkg::OUT_W-1:0] result;

  biqd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  biqd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .x      (s1_x),
    .x2     (in_hist1),
    .y1     (out_hist0),
    .y2     (out_hist1),
    .cfg    (cfg),
    .y_new  (y_new),
    .result (result)
  );

  // Result register frees up when empty or being taken this cycle.
  assign s1_fire   = s1_valid && (!out_valid || dout.ready);
  assign din.ready = !s1_valid || s1_fire;
  assign in_fire   = din.valid && din.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x <= din.sample_in;
    end
  end

  // History shifts once per filtered sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_hist0  <= '0;
      in_hist1  <= '0;
      out_hist0 <= '0;
      out_hist1 <= '0;
    end else if (s1_fire) begin
      in_hist0  <= s1_x;
      in_hist1  <= in_hist0;
      out_hist0 <= y_new;
      out_hist1 <= out_hist0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;

  // ---- checks ----
  a_rst_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid set right after reset");

  a_fire_loads_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("filtered sample lost between stages");

  a_hist_shift: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> (in_hist1 == $past(in_hist0)) && (out_hist1 == $past(out_hist0)))
    else $error("history did not shift with the sample");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> din.ready)
    else $error("input stalled with an empty result register");

endmodule
